>>> sv/distance_constraint_projection_assert.svh
// assertion macros shared by the distance constraint projection checks
// no dependencies; take in with a plain include
`ifndef DISTANCE_CONSTRAINT_PROJECTION_ASSERT_SVH
`define DISTANCE_CONSTRAINT_PROJECTION_ASSERT_SVH

// same-cycle implication
`define DCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/dcp_pkg.sv
// widths, constants and stage payload types of the distance constraint projection
// no dependencies; used by the square root, the dividers and the top level
package dcp_pkg;

   localparam int COORD_W  = 32;
   localparam int EXT_W    = 36;
   localparam int DIFF_W   = 33;
   localparam int MASS_W   = 24;
   localparam int WSUM_W   = 25;
   localparam int REST_W   = 31;
   localparam int STIFF_W  = 17;
   localparam int KW_W     = 41;
   localparam int KW_LO_W  = 21;
   localparam int SQ_W     = 66;
   localparam int LEN_W    = 33;
   localparam int DEN0_W   = 58;
   localparam int PK_W     = 74;
   localparam int CHUNK_W  = 25;
   localparam int PP_W     = 58;
   localparam int NUM_W    = 108;
   localparam int DEN_W    = 75;
   localparam int QUO_W    = 35;
   localparam int SQ_STEPS = 33;
   localparam int SQ_REM_W = 35;
   localparam int DIV_LAT  = QUO_W + 1;
   localparam int HALF_SHIFT = 15;
   localparam int DEN_SHIFT  = 16;

   localparam logic [STIFF_W-1:0] STIFF_RESET = 17'd65536;
   localparam logic [QUO_W-1:0]   MAG_LIMIT   = 35'h4_0000_0000;
   localparam logic [COORD_W-1:0] SAT_MAX     = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_MIN     = 32'h8000_0000;

   typedef logic [2:0][COORD_W-1:0] vec_type;
   typedef logic [2:0][DIFF_W-1:0]  dm_type;
   typedef logic [1:0][KW_W-1:0]    kw_type;

   // before the square root
   typedef struct packed {
      vec_type              a;
      vec_type              b;
      logic [2:0]           d_neg;
      dm_type               dm;
      logic [REST_W-1:0]    rest;
      kw_type               kw;
      logic [WSUM_W-1:0]    wsum;
   } pre_type;

   // after the length is known
   typedef struct packed {
      vec_type              a;
      vec_type              b;
      logic [2:0]           d_neg;
      dm_type               dm;
      kw_type               kw;
      logic [LEN_W-1:0]     len_err;
      logic                 diff_neg;
      logic [DEN0_W-1:0]    den0;
      logic                 degen;
   } len_type;

   // carried around the dividers
   typedef struct packed {
      vec_type              a;
      vec_type              b;
      logic [2:0]           neg;
      logic                 degen;
   } pos_type;

   typedef struct packed {
      vec_type              a;
      vec_type              b;
      logic                 degen;
   } res_type;

endpackage

>>> sv/dcp_isqrt.sv
// pipelined floor square root, one result bit per stage
// depends on dcp_pkg
module dcp_isqrt
   import dcp_pkg::*;
(
   input  logic                clock,
   input  logic                adv,
   input  logic [SQ_W-1:0]     rad,
   output logic [LEN_W-1:0]    root
);

   logic [SQ_REM_W-1:0] rem_ff  [SQ_STEPS-1];
   logic [SQ_W-1:0]     rad_ff  [SQ_STEPS-1];
   logic [LEN_W-1:0]    root_ff [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      logic [SQ_REM_W-1:0] rem_prev;
      logic [SQ_W-1:0]     rad_prev;
      logic [LEN_W-1:0]    root_prev;
      logic [SQ_REM_W+1:0] t;
      logic [SQ_REM_W+1:0] trial;
      logic                ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign rad_prev  = rad;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // bring down the next digit pair and try root*4+1
      assign t     = {rem_prev, rad_prev[SQ_W-1 -: 2]};
      assign trial = {{(SQ_REM_W-LEN_W){1'b0}}, root_prev, 2'b01};
      assign ge    = (t >= trial);

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k] <= {root_prev[LEN_W-2:0], ge};
         end
      end

      if (k < SQ_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k] <= ge ? SQ_REM_W'(t - trial) : SQ_REM_W'(t);
               rad_ff[k] <= {rad_prev[SQ_W-3:0], 2'b00};
            end
         end
      end
   end

   assign root = root_ff[SQ_STEPS-1];

endmodule

>>> sv/dcp_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on dcp_pkg
module dcp_div
   import dcp_pkg::*;
(
   input  logic                clock,
   input  logic                adv,
   input  logic [NUM_W-1:0]    num,
   input  logic [DEN_W-1:0]    den,
   output logic [QUO_W-1:0]    quo,
   output logic                ovf
);

   logic [DEN_W-1:0] r_ff   [QUO_W];
   logic [QUO_W-1:0] l_ff   [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] q_ff   [QUO_W];
   logic             ovf_ff [QUO_W+1];

   // load the first stage and flag a quotient that would not fit in its width
   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0]   <= DEN_W'(num[NUM_W-1:QUO_W]);
         l_ff[0]   <= num[QUO_W-1:0];
         den_ff[0] <= den;
         ovf_ff[0] <= (DEN_W'(num[NUM_W-1:QUO_W]) >= den);
      end
   end

   for (genvar j = 1; j <= QUO_W; j++) begin : g_step
      logic [DEN_W:0]   t;
      logic [DEN_W:0]   dd;
      logic [QUO_W-1:0] q_prev;
      logic             ge;

      if (j == 1) begin : g_first
         assign q_prev = '0;
      end else begin : g_next
         assign q_prev = q_ff[j-2];
      end

      assign t  = {r_ff[j-1], l_ff[j-1][QUO_W-1]};
      assign dd = {1'b0, den_ff[j-1]};
      assign ge = (t >= dd);

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[j-1] <= {q_prev[QUO_W-2:0], ge};
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end

      if (j < QUO_W) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               r_ff[j]   <= ge ? DEN_W'(t - dd) : DEN_W'(t);
               l_ff[j]   <= {l_ff[j-1][QUO_W-2:0], 1'b0};
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign quo = q_ff[QUO_W-1];
   assign ovf = ovf_ff[QUO_W];

endmodule

>>> sv/distance_constraint_projection.sv
// throughput: one word per cycle while the skid register is empty; set by the 33-stage
//   square root and the 36-stage dividers, each retiring one bit per stage, the
//   dividers' first stage apart
// a word behind a held result goes to a skid register, stopping the pipeline next cycle
// reset: synchronous, clears valid bits and sets stiffness to 1.0; no clearing pass
module distance_constraint_projection
   import dcp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [STIFF_W-1:0]  csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COORD_W-1:0]  req_pos_a_x,
   input  logic [COORD_W-1:0]  req_pos_a_y,
   input  logic [COORD_W-1:0]  req_pos_a_z,
   input  logic [COORD_W-1:0]  req_pos_b_x,
   input  logic [COORD_W-1:0]  req_pos_b_y,
   input  logic [COORD_W-1:0]  req_pos_b_z,
   input  logic [MASS_W-1:0]   req_inv_mass_a,
   input  logic [MASS_W-1:0]   req_inv_mass_b,
   input  logic [REST_W-1:0]   req_rest_length,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COORD_W-1:0]  rsp_new_a_x,
   output logic [COORD_W-1:0]  rsp_new_a_y,
   output logic [COORD_W-1:0]  rsp_new_a_z,
   output logic [COORD_W-1:0]  rsp_new_b_x,
   output logic [COORD_W-1:0]  rsp_new_b_y,
   output logic [COORD_W-1:0]  rsp_new_b_z,
   output logic                rsp_degenerate
);

   localparam int PIPE_STAGES = 3 + SQ_STEPS + 6 + DIV_LAT + 2;

   function automatic logic [COORD_W-1:0] sat_coord(input logic [EXT_W-1:0] v);
      if (v[EXT_W-1:COORD_W-1] == '0 || v[EXT_W-1:COORD_W-1] == '1) begin
         return v[COORD_W-1:0];
      end
      return v[EXT_W-1] ? SAT_MIN : SAT_MAX;
   endfunction

   logic [STIFF_W-1:0]     stiff_ff;
   logic                   adv;
   logic [PIPE_STAGES-1:0] vld_ff;
   logic                   pv;
   logic                   out_v_ff;
   logic                   skid_v_ff;
   res_type                out_ff;
   res_type                skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= STIFF_RESET;
      end else if (csr_write_enable) begin
         stiff_ff <= csr_write_data;
      end
   end

   // whole pipeline moves together; only a full skid register holds it
   assign adv       = !skid_v_ff;
   assign req_ready = adv;
   assign pv        = vld_ff[PIPE_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_STAGES-2:0], req_valid};
      end
   end

   // stage 1: differences, magnitudes, stiffness times mass, mass sum
   pre_type s1_in;
   pre_type s1_ff;

   always_comb begin
      logic [DIFF_W-1:0] diff;
      s1_in.a[0] = req_pos_a_x;
      s1_in.a[1] = req_pos_a_y;
      s1_in.a[2] = req_pos_a_z;
      s1_in.b[0] = req_pos_b_x;
      s1_in.b[1] = req_pos_b_y;
      s1_in.b[2] = req_pos_b_z;
      for (int c = 0; c < 3; c++) begin
         diff = {s1_in.a[c][COORD_W-1], s1_in.a[c]} - {s1_in.b[c][COORD_W-1], s1_in.b[c]};
         s1_in.d_neg[c] = diff[DIFF_W-1];
         s1_in.dm[c]    = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      end
      s1_in.rest  = req_rest_length;
      s1_in.kw[0] = KW_W'(stiff_ff) * KW_W'(req_inv_mass_a);
      s1_in.kw[1] = KW_W'(stiff_ff) * KW_W'(req_inv_mass_b);
      s1_in.wsum  = WSUM_W'(req_inv_mass_a) + WSUM_W'(req_inv_mass_b);
   end

   // stage 2: squares; stage 3: their sum
   logic [2:0][SQ_W-1:0] sq_ff;
   pre_type              s2_ff;
   logic [SQ_W-1:0]      sum_ff;
   pre_type              s3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         for (int c = 0; c < 3; c++) begin
            sq_ff[c] <= SQ_W'(s1_ff.dm[c]) * SQ_W'(s1_ff.dm[c]);
         end
         s2_ff  <= s1_ff;
         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         s3_ff  <= s2_ff;
      end
   end

   logic [LEN_W-1:0] len;
   pre_type          sq_side_ff [SQ_STEPS];
   pre_type          pre;

   dcp_isqrt u_isqrt (
      .clock (clock),
      .adv   (adv),
      .rad   (sum_ff),
      .root  (len)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0] <= s3_ff;
         for (int k = 1; k < SQ_STEPS; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
   end

   assign pre = sq_side_ff[SQ_STEPS-1];

   // L1: length error, denominator base, degenerate test
   len_type l1_in;
   len_type l1_ff;

   always_comb begin
      l1_in.a        = pre.a;
      l1_in.b        = pre.b;
      l1_in.d_neg    = pre.d_neg;
      l1_in.dm       = pre.dm;
      l1_in.kw       = pre.kw;
      l1_in.diff_neg = (len < LEN_W'(pre.rest));
      l1_in.len_err  = l1_in.diff_neg ? (LEN_W'(pre.rest) - len) : (len - LEN_W'(pre.rest));
      l1_in.den0     = DEN0_W'(len) * DEN0_W'(pre.wsum);
      l1_in.degen    = (len == '0) || (pre.wsum == '0);
   end

   // L2..L6: numerator dm * kw * len_err + half, in partial products
   logic [1:0][PK_W-1:0]          pklo_ff;
   logic [1:0][PK_W-1:0]          pkhi_ff;
   logic [1:0][PK_W-1:0]          pw_ff;
   logic [2:0][1:0][2:0][PP_W-1:0] pp_ff;
   logic [2:0][1:0][NUM_W-1:0]    s_ff;
   logic [2:0][1:0][PP_W-1:0]     pp2_ff;
   logic [2:0][1:0][NUM_W-1:0]    n_ff;
   logic [DEN_W-1:0]              den_ff;
   len_type                       l2_ff;
   len_type                       l3_ff;
   len_type                       l4_ff;
   len_type                       l5_ff;
   pos_type                       l6_ff;
   logic [2:0][1:0][2:0][PP_W-1:0] pp_in;

   always_comb begin
      logic [CHUNK_W-1:0] chunk;
      for (int c = 0; c < 3; c++) begin
         for (int p = 0; p < 2; p++) begin
            for (int k = 0; k < 3; k++) begin
               chunk = CHUNK_W'(pw_ff[p] >> (k * CHUNK_W));
               pp_in[c][p][k] = PP_W'(l3_ff.dm[c]) * PP_W'(chunk);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l1_ff <= l1_in;
         for (int p = 0; p < 2; p++) begin
            pklo_ff[p] <= PK_W'(l1_ff.kw[p][KW_LO_W-1:0]) * PK_W'(l1_ff.len_err);
            pkhi_ff[p] <= PK_W'(l1_ff.kw[p][KW_W-1:KW_LO_W]) * PK_W'(l1_ff.len_err);
            pw_ff[p]   <= pklo_ff[p] + (pkhi_ff[p] << KW_LO_W);
         end
         l2_ff <= l1_ff;
         l3_ff <= l2_ff;
         pp_ff <= pp_in;
         l4_ff <= l3_ff;
         for (int c = 0; c < 3; c++) begin
            for (int p = 0; p < 2; p++) begin
               s_ff[c][p]   <= NUM_W'(pp_ff[c][p][0]) + (NUM_W'(pp_ff[c][p][1]) << CHUNK_W);
               pp2_ff[c][p] <= pp_ff[c][p][2];
               n_ff[c][p]   <= s_ff[c][p] + (NUM_W'(pp2_ff[c][p]) << (2 * CHUNK_W))
                               + (NUM_W'(l5_ff.den0) << HALF_SHIFT);
            end
         end
         l5_ff    <= l4_ff;
         den_ff   <= DEN_W'(l5_ff.den0) << DEN_SHIFT;
         l6_ff.a     <= l5_ff.a;
         l6_ff.b     <= l5_ff.b;
         l6_ff.neg   <= l5_ff.d_neg ^ {3{l5_ff.diff_neg}};
         l6_ff.degen <= l5_ff.degen;
      end
   end

   // six dividers: three axes, two points
   logic [2:0][1:0][QUO_W-1:0] quo;
   logic [2:0][1:0]            ovf;
   pos_type                    div_side_ff [DIV_LAT];

   for (genvar c = 0; c < 3; c++) begin : g_axis
      for (genvar p = 0; p < 2; p++) begin : g_point
         dcp_div u_div (
            .clock (clock),
            .adv   (adv),
            .num   (n_ff[c][p]),
            .den   (den_ff),
            .quo   (quo[c][p]),
            .ovf   (ovf[c][p])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_side_ff[0] <= l6_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            div_side_ff[k] <= div_side_ff[k-1];
         end
      end
   end

   // F1: clamp magnitudes; F2: apply and saturate
   logic [2:0][1:0][QUO_W-1:0] mag_ff;
   pos_type                    f1_ff;
   res_type                    f2_in;
   res_type                    f2_ff;

   always_comb begin
      logic [EXT_W-1:0] aa;
      logic [EXT_W-1:0] bb;
      logic [EXT_W-1:0] ma;
      logic [EXT_W-1:0] mb;
      logic [EXT_W-1:0] ra;
      logic [EXT_W-1:0] rb;
      for (int c = 0; c < 3; c++) begin
         aa = {{(EXT_W-COORD_W){f1_ff.a[c][COORD_W-1]}}, f1_ff.a[c]};
         bb = {{(EXT_W-COORD_W){f1_ff.b[c][COORD_W-1]}}, f1_ff.b[c]};
         ma = EXT_W'(mag_ff[c][0]);
         mb = EXT_W'(mag_ff[c][1]);
         ra = f1_ff.neg[c] ? (aa + ma) : (aa - ma);
         rb = f1_ff.neg[c] ? (bb - mb) : (bb + mb);
         f2_in.a[c] = f1_ff.degen ? f1_ff.a[c] : sat_coord(ra);
         f2_in.b[c] = f1_ff.degen ? f1_ff.b[c] : sat_coord(rb);
      end
      f2_in.degen = f1_ff.degen;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            for (int p = 0; p < 2; p++) begin
               mag_ff[c][p] <= (ovf[c][p] || quo[c][p] > MAG_LIMIT) ? MAG_LIMIT : quo[c][p];
            end
         end
         f1_ff <= div_side_ff[DIV_LAT-1];
         f2_ff <= f2_in;
      end
   end

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_ready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (pv) begin
         if (out_v_ff && !rsp_ready) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_ready) begin
            out_ff <= skid_ff;
         end
      end else if (pv) begin
         if (out_v_ff && !rsp_ready) begin
            skid_ff <= f2_ff;
         end else begin
            out_ff <= f2_ff;
         end
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_new_a_x    = out_ff.a[0];
   assign rsp_new_a_y    = out_ff.a[1];
   assign rsp_new_a_z    = out_ff.a[2];
   assign rsp_new_b_x    = out_ff.b[0];
   assign rsp_new_b_y    = out_ff.b[1];
   assign rsp_new_b_z    = out_ff.b[2];
   assign rsp_degenerate = out_ff.degen;

endmodule

>>> sv/dcp_checker.sv
// port-level checks of the distance constraint projection, bound to the top level
// depends on distance_constraint_projection_assert.svh
`include "distance_constraint_projection_assert.svh"

module dcp_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [31:0]         rsp_new_a_x,
   input logic                rsp_degenerate
);

   logic [7:0] inflight_ff;
   logic [7:0] inflight_in;

   // words taken in and not yet delivered
   always_comb begin
      inflight_in = inflight_ff;
      if (req_valid && req_ready) begin
         inflight_in = inflight_in + 8'd1;
      end
      if (rsp_valid && rsp_ready) begin
         inflight_in = inflight_in - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `DCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_new_a_x) && $stable(rsp_degenerate), "rsp word changed while held")
   `DCP_ASSERT_NOW(a_no_phantom, clock, reset, rsp_valid,
      inflight_ff != 8'd0, "rsp word with no request outstanding")
   `DCP_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready,
      rsp_valid, "input stalled with no result waiting")
   `DCP_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset),
      !rsp_valid, "rsp valid right after reset")

endmodule

bind distance_constraint_projection dcp_checker u_dcp_checker (.*);

>>> tb/distance_constraint_projection_test.sv
// self-checking testbench for the distance constraint projection block
// needs dcp_pkg and distance_constraint_projection; a scoreboard class predicts every word
`timescale 1ns / 100ps

module distance_constraint_projection_test;
   import dcp_pkg::*;

   typedef struct {
      logic [2:0][COORD_W-1:0] a;
      logic [2:0][COORD_W-1:0] b;
      logic [MASS_W-1:0]       wa;
      logic [MASS_W-1:0]       wb;
      logic [REST_W-1:0]       rest;
   } constraint_word_type;

   typedef struct {
      logic [2:0][COORD_W-1:0] a;
      logic [2:0][COORD_W-1:0] b;
      logic                    degen;
   } projected_word_type;

   class projection_scoreboard_type;
      logic [STIFF_W-1:0] stiffness;
      projected_word_type pending[$];
      int                 errors;
      int                 checked;
      int                 degenerate_seen;

      function new();
         stiffness = STIFF_RESET;
         errors = 0;
         checked = 0;
         degenerate_seen = 0;
      endfunction

      function logic [COORD_W-1:0] clamp32(longint v);
         if (v > 64'sd2147483647) return SAT_MAX;
         if (v < -64'sd2147483648) return SAT_MIN;
         return v[COORD_W-1:0];
      endfunction

      function projected_word_type project(constraint_word_type w);
         projected_word_type r;
         longint av[3], bv[3], dv[3];
         logic [127:0] dmag[3];
         logic [127:0] sq, len, t, den, half, num, q, mag, len_err, wsum;
         longint diff, delta;
         bit flip;
         sq = 0;
         for (int c = 0; c < 3; c++) begin
            av[c] = longint'($signed(w.a[c]));
            bv[c] = longint'($signed(w.b[c]));
            dv[c] = av[c] - bv[c];
            dmag[c] = 128'(dv[c] < 0 ? -dv[c] : dv[c]);
            sq += dmag[c] * dmag[c];
         end
         len = 0;
         for (int i = 33; i >= 0; i--) begin
            t = len | (128'd1 << i);
            if (t * t <= sq) len = t;
         end
         wsum = 128'(w.wa) + 128'(w.wb);
         r.a = w.a;
         r.b = w.b;
         r.degen = 1'b1;
         if (len == 0 || wsum == 0) return r;
         r.degen = 1'b0;
         diff = longint'(len) - longint'(w.rest);
         len_err = 128'(diff < 0 ? -diff : diff);
         den = len * wsum * 128'd65536;
         half = len * wsum * 128'd32768;
         for (int c = 0; c < 3; c++) begin
            flip = (dv[c] < 0) != (diff < 0);
            num = dmag[c] * 128'(stiffness) * 128'(w.wa) * len_err + half;
            q = num / den;
            mag = (q > 128'(MAG_LIMIT)) ? 128'(MAG_LIMIT) : q;
            delta = flip ? -longint'(mag) : longint'(mag);
            r.a[c] = clamp32(av[c] - delta);
            num = dmag[c] * 128'(stiffness) * 128'(w.wb) * len_err + half;
            q = num / den;
            mag = (q > 128'(MAG_LIMIT)) ? 128'(MAG_LIMIT) : q;
            delta = flip ? -longint'(mag) : longint'(mag);
            r.b[c] = clamp32(bv[c] + delta);
         end
         return r;
      endfunction

      function void note_request(constraint_word_type w);
         pending.push_back(project(w));
      endfunction

      function void check_response(projected_word_type got);
         projected_word_type want;
         string axis;
         if (pending.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.degen) degenerate_seen++;
         for (int c = 0; c < 3; c++) begin
            axis = (c == 0) ? "x" : (c == 1) ? "y" : "z";
            if (got.a[c] !== want.a[c]) begin
               $error("new_a_%s expected %h actual %h", axis, want.a[c], got.a[c]);
               errors++;
            end
            if (got.b[c] !== want.b[c]) begin
               $error("new_b_%s expected %h actual %h", axis, want.b[c], got.b[c]);
               errors++;
            end
         end
         if (got.degen !== want.degen) begin
            $error("degenerate expected %b actual %b", want.degen, got.degen);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [STIFF_W-1:0]  csr_write_data;
   logic                req_valid;
   logic                req_ready;
   logic [COORD_W-1:0]  req_pos_a_x, req_pos_a_y, req_pos_a_z;
   logic [COORD_W-1:0]  req_pos_b_x, req_pos_b_y, req_pos_b_z;
   logic [MASS_W-1:0]   req_inv_mass_a, req_inv_mass_b;
   logic [REST_W-1:0]   req_rest_length;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [COORD_W-1:0]  rsp_new_a_x, rsp_new_a_y, rsp_new_a_z;
   logic [COORD_W-1:0]  rsp_new_b_x, rsp_new_b_y, rsp_new_b_z;
   logic                rsp_degenerate;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 100;

   projection_scoreboard_type board = new();
   int cycles = 0;
   int words_sent = 0;
   int settings_used = 0;
   int burst_left = 0;

   distance_constraint_projection dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pos_a_x(req_pos_a_x), .req_pos_a_y(req_pos_a_y), .req_pos_a_z(req_pos_a_z),
      .req_pos_b_x(req_pos_b_x), .req_pos_b_y(req_pos_b_y), .req_pos_b_z(req_pos_b_z),
      .req_inv_mass_a(req_inv_mass_a), .req_inv_mass_b(req_inv_mass_b),
      .req_rest_length(req_rest_length),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_a_x(rsp_new_a_x), .rsp_new_a_y(rsp_new_a_y), .rsp_new_a_z(rsp_new_a_z),
      .rsp_new_b_x(rsp_new_b_x), .rsp_new_b_y(rsp_new_b_y), .rsp_new_b_z(rsp_new_b_z),
      .rsp_degenerate(rsp_degenerate)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver stall pattern: free flow, random, sparse and mostly ready, chosen by cycles[9:8]
   always @(posedge clock) begin
      case (cycles[9:8])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= (cycles[1:0] == 2'd0);
         default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      projected_word_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.a = {rsp_new_a_z, rsp_new_a_y, rsp_new_a_x};
         got.b = {rsp_new_b_z, rsp_new_b_y, rsp_new_b_x};
         got.degen = rsp_degenerate;
         board.check_response(got);
      end
   end

   task automatic send_word(constraint_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      {req_pos_a_z, req_pos_a_y, req_pos_a_x} <= w.a;
      {req_pos_b_z, req_pos_b_y, req_pos_b_x} <= w.b;
      req_inv_mass_a <= w.wa;
      req_inv_mass_b <= w.wb;
      req_rest_length <= w.rest;
      do @(posedge clock); while (!req_ready);
      board.note_request(w);
      words_sent++;
   endtask

   // stiffness only changes with the pipeline empty
   task automatic set_stiffness(logic [STIFF_W-1:0] value);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.stiffness = value;
      settings_used++;
   endtask

   function automatic constraint_word_type random_word();
      constraint_word_type w;
      int kind;
      kind = $urandom_range(0, 9);
      for (int c = 0; c < 3; c++) begin
         w.a[c] = $urandom;
         w.b[c] = $urandom;
      end
      w.wa = MASS_W'($urandom);
      w.wb = MASS_W'($urandom);
      w.rest = REST_W'($urandom);
      if (kind < 6) begin
         // nearby points, modest masses, rest in the range of the distance
         for (int c = 0; c < 3; c++)
            w.b[c] = w.a[c] + 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
         w.wa = MASS_W'($urandom_range(0, 1 << 18));
         w.wb = MASS_W'($urandom_range(0, 1 << 18));
         w.rest = REST_W'($urandom_range(0, 1 << 22));
      end else if (kind == 6) begin
         w.b = w.a;
      end else if (kind == 7) begin
         w.wa = 0;
         if ($urandom_range(0, 1)) w.wb = 0;
      end else if (kind == 8) begin
         w.rest = (REST_W)'($urandom_range(0, 3));
      end
      return w;
   endfunction

   function automatic constraint_word_type make_word(int ax, int ay, int az, int bx, int by,
                                                     int bz, int wa, int wb, int rest);
      constraint_word_type w;
      w.a = {az, ay, ax};
      w.b = {bz, by, bx};
      w.wa = MASS_W'(wa);
      w.wb = MASS_W'(wb);
      w.rest = REST_W'(rest);
      return w;
   endfunction

   task automatic run_directed();
      int big, low;
      big = 32'h7FFF_FFFF;
      low = 32'h8000_0000;
      send_word(make_word(0, 0, 0, 0, 0, 0, 65536, 65536, 65536));          // coincident
      send_word(make_word(65536, 0, 0, 0, 0, 0, 0, 0, 0));                 // zero mass sum
      send_word(make_word(3 << 16, 4 << 16, 0, 0, 0, 0, 65536, 65536, 65536));
      send_word(make_word(3 << 16, 4 << 16, 0, 0, 0, 0, 65536, 0, 5 << 16));
      send_word(make_word(0, 0, 65536, 0, 0, 0, 0, 65536, 10 << 16));
      send_word(make_word(big, big, big, low, low, low, 24'hFFFFFF, 24'hFFFFFF, 0));
      send_word(make_word(low, low, low, big, big, big, 24'hFFFFFF, 1, 31'h7FFFFFFF));
      send_word(make_word(big, 0, 0, low, 0, 0, 1, 24'hFFFFFF, 31'h7FFFFFFF));
      send_word(make_word(1, 0, 0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 31'h7FFFFFFF));
      send_word(make_word(1, 1, 1, 0, 0, 0, 1, 1, 0));
      send_word(make_word(-5, 7, -9, 11, -13, 15, 40000, 20000, 3));
      send_word(make_word(big, big, big, big, big, big, 65536, 65536, 0));
      send_word(make_word(low, 0, 0, low, 0, 1, 24'hFFFFFF, 0, 31'h7FFFFFFF));
      send_word(make_word(0, low, 0, 0, big, 0, 0, 24'hFFFFFF, 1));
      send_word(make_word(12345678, -7654321, 2222222, -9999, 31, 0, 300000, 5, 777777));
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      {req_pos_a_x, req_pos_a_y, req_pos_a_z} = '0;
      {req_pos_b_x, req_pos_b_y, req_pos_b_z} = '0;
      req_inv_mass_a = '0;
      req_inv_mass_b = '0;
      req_rest_length = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      set_stiffness(17'd0);
      run_directed();
      set_stiffness(17'h1FFFF);
      run_directed();
      set_stiffness(STIFF_RESET);
      repeat (400) send_word(random_word());
      set_stiffness(17'd32768);
      repeat (300) send_word(random_word());
      set_stiffness(17'd0);
      repeat (150) send_word(random_word());
      set_stiffness(17'h1FFFF);
      repeat (300) send_word(random_word());
      set_stiffness(17'($urandom_range(1, 65535)));
      repeat (300) send_word(random_word());

      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d constraint words checked over %0d stiffness settings, %0d degenerate",
               board.checked, settings_used + 1, board.degenerate_seen);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
